FILE: design/dsa_pkg.sv
// Package for the descriptor slot allocator: widths, opcodes, status codes,
// controller states and the command and status bundles between controller and datapath.
// Used by every module of the block; depends on nothing.
`default_nettype none

package dsa_pkg;

  // Default number of slots in the busy map.
  localparam int MAX_SLOTS_DEF = 1024;

  // Busy map word organization.
  localparam int WORD_W = 32;
  localparam int BIT_W  = $clog2(WORD_W);

  // Field widths.
  localparam int CAP_W      = 11;
  localparam int HS_W       = 13;
  localparam int ADDR_W     = 64;
  localparam int SLOT_NUM_W = 10;
  localparam int OPCODE_W   = 2;
  localparam int STATUS_W   = 3;

  // Configuration port.
  localparam int PDATA_W = 64;
  localparam int PADDR_W = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_RESET  = 2'd2,
    OP_LOOKUP = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_NOINIT  = 3'd1,
    STAT_FULL    = 3'd2,
    STAT_BADIDX  = 3'd3,
    STAT_ALREADY = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_CAPACITY    = 2'd0,
    REG_HANDLE_SIZE = 2'd1,
    REG_CPU_BASE    = 2'd2,
    REG_GPU_BASE    = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_FETCH,
    S_SCAN,
    S_CHECK,
    S_WIPE,
    S_MUL,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch;
    logic    rd;
    logic    scan_init;
    logic    scan_step;
    logic    alloc_commit;
    logic    free_commit;
    logic    take_idx;
    logic    clr_start;
    logic    clr_write;
    logic    counts_reset;
    logic    mul;
    logic    set_res;
    status_t res_code;
    logic    res_addr;
    logic    load_out;
  } dsa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic cap_zero;
    logic busy_full;
    logic idx_bad;
    logic found;
    logic scan_end;
    logic bit_busy;
    logic clr_last;
    logic out_blocked;
  } dsa_stat_t;

  // Position of the lowest set bit of a busy map word (0 when none is set).
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

FILE: design/dsa_ctrl.sv
// Controller state machine of the descriptor slot allocator.
// Depends on dsa_pkg; drives the datapath through dsa_cmd_t and reads dsa_stat_t.
`default_nettype none

module dsa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  dsa_pkg::dsa_stat_t stat,
  output dsa_pkg::dsa_cmd_t  cmd
);

  dsa_pkg::state_t state, state_next;

  // State register; reset starts the clearing pass over the busy map.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsa_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.res_code = dsa_pkg::STAT_OK;
    req_ready    = 1'b0;
    unique case (state)
      dsa_pkg::S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (stat.clr_last) begin
          state_next = dsa_pkg::S_IDLE;
        end
      end
      dsa_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = dsa_pkg::S_DECIDE;
        end
      end
      dsa_pkg::S_DECIDE: begin
        if (stat.cap_zero) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = dsa_pkg::STAT_NOINIT;
          state_next   = dsa_pkg::S_DONE;
        end else begin
          unique case (stat.op)
            dsa_pkg::OP_ALLOC: begin
              if (stat.busy_full) begin
                cmd.set_res  = 1'b1;
                cmd.res_code = dsa_pkg::STAT_FULL;
                state_next   = dsa_pkg::S_DONE;
              end else begin
                cmd.scan_init = 1'b1;
                state_next    = dsa_pkg::S_FETCH;
              end
            end
            dsa_pkg::OP_FREE: begin
              if (stat.idx_bad) begin
                cmd.set_res  = 1'b1;
                cmd.res_code = dsa_pkg::STAT_BADIDX;
                state_next   = dsa_pkg::S_DONE;
              end else begin
                state_next = dsa_pkg::S_FETCH;
              end
            end
            dsa_pkg::OP_RESET: begin
              cmd.clr_start = 1'b1;
              state_next    = dsa_pkg::S_WIPE;
            end
            dsa_pkg::OP_LOOKUP: begin
              cmd.set_res = 1'b1;
              if (stat.idx_bad) begin
                cmd.res_code = dsa_pkg::STAT_BADIDX;
                state_next   = dsa_pkg::S_DONE;
              end else begin
                cmd.take_idx = 1'b1;
                cmd.res_addr = 1'b1;
                state_next   = dsa_pkg::S_MUL;
              end
            end
            default: state_next = dsa_pkg::S_DONE;
          endcase
        end
      end
      dsa_pkg::S_FETCH: begin
        cmd.rd = 1'b1;
        state_next = (stat.op == dsa_pkg::OP_FREE) ? dsa_pkg::S_CHECK : dsa_pkg::S_SCAN;
      end
      dsa_pkg::S_SCAN: begin
        if (stat.found) begin
          cmd.alloc_commit = 1'b1;
          cmd.set_res      = 1'b1;
          cmd.res_addr     = 1'b1;
          state_next       = dsa_pkg::S_MUL;
        end else if (stat.scan_end) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = dsa_pkg::STAT_FULL;
          state_next   = dsa_pkg::S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
          state_next    = dsa_pkg::S_FETCH;
        end
      end
      dsa_pkg::S_CHECK: begin
        cmd.set_res = 1'b1;
        if (stat.bit_busy) begin
          cmd.free_commit = 1'b1;
          cmd.res_addr    = 1'b1;
          state_next      = dsa_pkg::S_MUL;
        end else begin
          cmd.res_code = dsa_pkg::STAT_ALREADY;
          state_next   = dsa_pkg::S_DONE;
        end
      end
      dsa_pkg::S_WIPE: begin
        cmd.clr_write = 1'b1;
        if (stat.clr_last) begin
          cmd.counts_reset = 1'b1;
          state_next       = dsa_pkg::S_DONE;
        end
      end
      dsa_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = dsa_pkg::S_DONE;
      end
      dsa_pkg::S_DONE: begin
        if (!stat.out_blocked) begin
          cmd.load_out = 1'b1;
          state_next   = dsa_pkg::S_IDLE;
        end
      end
      default: state_next = dsa_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/dsa_datapath.sv
// Datapath of the descriptor slot allocator: busy map memory, word scan, counters,
// address multiplier and the result register. Depends on dsa_pkg; driven by dsa_ctrl.
`default_nettype none

module dsa_datapath #(
  parameter int MAX_SLOTS = dsa_pkg::MAX_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  dsa_pkg::dsa_cmd_t                 cmd,
  output dsa_pkg::dsa_stat_t                stat,
  input  logic [dsa_pkg::OPCODE_W-1:0]      opcode,
  input  logic [dsa_pkg::SLOT_NUM_W-1:0]    slot_number,
  input  logic [dsa_pkg::CAP_W-1:0]         capacity,
  input  logic [dsa_pkg::HS_W-1:0]          handle_size,
  input  logic [dsa_pkg::ADDR_W-1:0]        cpu_base,
  input  logic [dsa_pkg::ADDR_W-1:0]        gpu_base,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output logic [dsa_pkg::STATUS_W-1:0]      status,
  output logic [dsa_pkg::SLOT_NUM_W-1:0]    granted_slot,
  output logic [dsa_pkg::ADDR_W-1:0]        cpu_address,
  output logic [dsa_pkg::ADDR_W-1:0]        gpu_address,
  output logic [dsa_pkg::CAP_W-1:0]         used_count,
  output logic [dsa_pkg::CAP_W-1:0]         free_count
);

  localparam int WORD_W    = dsa_pkg::WORD_W;
  localparam int BIT_W     = dsa_pkg::BIT_W;
  localparam int CAP_W     = dsa_pkg::CAP_W;
  localparam int NUM_WORDS = (MAX_SLOTS + WORD_W - 1) / WORD_W;
  localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int SW        = WADDR_W + BIT_W;
  localparam int CW        = (SW > CAP_W) ? SW : CAP_W;
  localparam int PW        = SW + dsa_pkg::HS_W;
  localparam logic [BIT_W-1:0]   BIT_MAX   = BIT_W'(WORD_W - 1);
  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NUM_WORDS - 1);

  // Busy map, one bit per slot, WORD_W slots per word.
  logic [WORD_W-1:0] busy_mem [NUM_WORDS];
  logic [WORD_W-1:0] rd_data;

  // Allocator state.
  logic [CAP_W-1:0]   busy_total;
  logic [SW-1:0]      search_start;

  // Request and working registers.
  dsa_pkg::op_t                 op_q;
  logic [dsa_pkg::SLOT_NUM_W-1:0] idx_q;
  logic [WADDR_W-1:0]           scan_w;
  logic                         wrapped;
  logic [WADDR_W-1:0]           clr_addr;
  logic [SW-1:0]                res_slot;
  dsa_pkg::status_t             res_code;
  logic                         res_addr;
  logic [PW-1:0]                prod;

  // Derived values.
  logic [CAP_W-1:0]   cap;
  logic [CW-1:0]      cap_ext;
  logic [SW-1:0]      start_slot;
  logic [SW-1:0]      last_slot;
  logic [WADDR_W-1:0] start_w;
  logic [WADDR_W-1:0] last_w;
  logic [SW-1:0]      idx_slot;
  logic [WADDR_W-1:0] idx_w;
  logic [BIT_W-1:0]   lo_bit;
  logic [BIT_W-1:0]   hi_bit;
  logic [WORD_W-1:0]  scan_mask;
  logic [WORD_W-1:0]  cand;
  logic [BIT_W-1:0]   fbit;
  logic [SW-1:0]      found_slot;
  logic [SW-1:0]      found_next;
  logic               mem_we;
  logic [WADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0]  wr_data;
  logic [WADDR_W-1:0] rd_addr;

  // Effective capacity and scan window.
  always_comb begin
    cap        = (32'(capacity) > 32'(MAX_SLOTS)) ? CAP_W'(MAX_SLOTS) : capacity;
    cap_ext    = CW'(cap);
    start_slot = (CW'(search_start) < cap_ext) ? search_start : '0;
    last_slot  = SW'(cap - CAP_W'(1));
    start_w    = start_slot[SW-1:BIT_W];
    last_w     = last_slot[SW-1:BIT_W];
    idx_slot   = SW'(idx_q);
    idx_w      = idx_slot[SW-1:BIT_W];
  end

  // Free-slot search within the word just read.
  always_comb begin
    lo_bit     = (!wrapped && scan_w == start_w) ? start_slot[BIT_W-1:0] : '0;
    hi_bit     = (scan_w == last_w) ? last_slot[BIT_W-1:0] : BIT_MAX;
    scan_mask  = ({WORD_W{1'b1}} << lo_bit) & ({WORD_W{1'b1}} >> (BIT_MAX - hi_bit));
    cand       = ~rd_data & scan_mask;
    fbit       = dsa_pkg::lowest_set(cand);
    found_slot = {scan_w, fbit};
    found_next = ((CW'(found_slot) + CW'(1)) < cap_ext) ? found_slot + SW'(1) : '0;
  end

  // Status toward the controller.
  always_comb begin
    stat.op          = op_q;
    stat.cap_zero    = (cap == '0);
    stat.busy_full   = (busy_total >= cap);
    stat.idx_bad     = (CW'(idx_q) >= cap_ext);
    stat.found       = |cand;
    stat.scan_end    = wrapped && (scan_w == start_w || scan_w == last_w);
    stat.bit_busy    = rd_data[idx_slot[BIT_W-1:0]];
    stat.clr_last    = (clr_addr == LAST_WORD);
    stat.out_blocked = rsp_valid && !rsp_ready;
  end

  // Busy map port muxing.
  always_comb begin
    mem_we  = cmd.clr_write || cmd.alloc_commit || cmd.free_commit;
    rd_addr = (op_q == dsa_pkg::OP_FREE) ? idx_w : scan_w;
    if (cmd.clr_write) begin
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (cmd.alloc_commit) begin
      wr_addr = scan_w;
      wr_data = rd_data | (WORD_W'(1) << fbit);
    end else begin
      wr_addr = idx_w;
      wr_data = rd_data & ~(WORD_W'(1) << idx_slot[BIT_W-1:0]);
    end
  end

  // Busy map memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      busy_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data <= busy_mem[rd_addr];
    end
  end

  // Control state: counters, pointers and the result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy_total   <= '0;
      search_start <= '0;
      clr_addr     <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cmd.clr_start) begin
        clr_addr <= '0;
      end else if (cmd.clr_write && !stat.clr_last) begin
        clr_addr <= clr_addr + WADDR_W'(1);
      end
      if (cmd.counts_reset) begin
        busy_total   <= '0;
        search_start <= '0;
      end else if (cmd.alloc_commit) begin
        busy_total   <= busy_total + CAP_W'(1);
        search_start <= found_next;
      end else if (cmd.free_commit) begin
        if (busy_total != '0) begin
          busy_total <= busy_total - CAP_W'(1);
        end
        if (CW'(idx_slot) < CW'(search_start)) begin
          search_start <= idx_slot;
        end
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Request capture, scan position, result slot and address product.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q     <= dsa_pkg::op_t'(opcode);
      idx_q    <= slot_number;
      res_slot <= '0;
      res_code <= dsa_pkg::STAT_OK;
      res_addr <= 1'b0;
    end
    if (cmd.scan_init) begin
      scan_w  <= start_w;
      wrapped <= 1'b0;
    end else if (cmd.scan_step) begin
      if (scan_w == last_w) begin
        scan_w  <= '0;
        wrapped <= 1'b1;
      end else begin
        scan_w <= scan_w + WADDR_W'(1);
      end
    end
    if (cmd.set_res) begin
      res_code <= cmd.res_code;
      res_addr <= cmd.res_addr;
    end
    if (cmd.alloc_commit) begin
      res_slot <= found_slot;
    end else if (cmd.free_commit || cmd.take_idx) begin
      res_slot <= idx_slot;
    end
    if (cmd.mul) begin
      prod <= PW'(res_slot) * PW'(handle_size);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status       <= res_code;
      granted_slot <= dsa_pkg::SLOT_NUM_W'(res_slot);
      cpu_address  <= res_addr ? cpu_base + dsa_pkg::ADDR_W'(prod) : '0;
      gpu_address  <= res_addr ? gpu_base + dsa_pkg::ADDR_W'(prod) : '0;
      used_count   <= busy_total;
      free_count   <= (cap > busy_total) ? cap - busy_total : '0;
    end
  end

  // The allocated count can never exceed the number of map bits.
  assert property (@(posedge clk) disable iff (rst) 32'(busy_total) <= 32'(MAX_SLOTS))
    else $error("busy_total exceeds the busy map size");

  // An allocation always grants a slot inside the effective capacity.
  assert property (@(posedge clk) disable iff (rst) cmd.alloc_commit |-> CW'(found_slot) < cap_ext)
    else $error("allocation granted a slot beyond capacity");

  // An allocation raises the count by exactly one.
  assert property (@(posedge clk) disable iff (rst)
    cmd.alloc_commit |=> busy_total == $past(busy_total) + CAP_W'(1))
    else $error("busy_total did not follow an allocation");

  // A failed request reports slot zero.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != dsa_pkg::STAT_OK |-> granted_slot == '0)
    else $error("failed request reports a nonzero slot");

endmodule

`default_nettype wire

FILE: design/descriptor_slot_allocator.sv
// Descriptor slot allocator. Takes one request (allocate, free, reset all, lookup) per
// transaction and returns one result holding status, slot, CPU and GPU addresses and the
// used and free counts. After reset the block clears its busy map, one 32-slot word per
// cycle, and takes no request until done. A lookup multiplies the slot by the handle
// size for the addresses. A request that fails on the first check (not initialized, bad
// index, count already at capacity) goes straight to the result. A free reads the word
// of its slot and checks the bit; a successful free then computes the addresses. An
// allocate runs a next-fit scan that reads the busy map one 32-slot word at a time, each
// word fetched and then searched, and computes the addresses for the slot it finds. A
// reset-all clears the whole busy map, one word per cycle.
// One request is in work at a time; the next is taken while the previous result still
// waits in the output register.
// Depends on dsa_pkg, dsa_ctrl and dsa_datapath.
`default_nettype none

module descriptor_slot_allocator #(
  parameter int MAX_SLOTS = dsa_pkg::MAX_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dsa_pkg::PADDR_W-1:0]       paddr,
  input  logic [dsa_pkg::PDATA_W-1:0]       pwdata,
  output logic [dsa_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready,
  // Request channel.
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic [dsa_pkg::OPCODE_W-1:0]      opcode,
  input  logic [dsa_pkg::SLOT_NUM_W-1:0]    slot_number,
  // Result channel.
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output logic [dsa_pkg::STATUS_W-1:0]      status,
  output logic [dsa_pkg::SLOT_NUM_W-1:0]    granted_slot,
  output logic [dsa_pkg::ADDR_W-1:0]        cpu_address,
  output logic [dsa_pkg::ADDR_W-1:0]        gpu_address,
  output logic [dsa_pkg::CAP_W-1:0]         used_count,
  output logic [dsa_pkg::CAP_W-1:0]         free_count
);

  logic [dsa_pkg::CAP_W-1:0]  capacity;
  logic [dsa_pkg::HS_W-1:0]   handle_size;
  logic [dsa_pkg::ADDR_W-1:0] cpu_base;
  logic [dsa_pkg::ADDR_W-1:0] gpu_base;
  dsa_pkg::reg_idx_t          reg_idx;
  logic                       cfg_we;

  dsa_pkg::dsa_cmd_t  cmd;
  dsa_pkg::dsa_stat_t stat;

  // Register decode; registers sit on 8-byte boundaries.
  assign pready  = 1'b1;
  assign reg_idx = dsa_pkg::reg_idx_t'(paddr[dsa_pkg::PADDR_W-1:3]);
  assign cfg_we  = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= '0;
      handle_size <= '0;
      cpu_base    <= '0;
      gpu_base    <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        dsa_pkg::REG_CAPACITY:    capacity    <= pwdata[dsa_pkg::CAP_W-1:0];
        dsa_pkg::REG_HANDLE_SIZE: handle_size <= pwdata[dsa_pkg::HS_W-1:0];
        dsa_pkg::REG_CPU_BASE:    cpu_base    <= pwdata;
        dsa_pkg::REG_GPU_BASE:    gpu_base    <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (reg_idx)
      dsa_pkg::REG_CAPACITY:    prdata = dsa_pkg::PDATA_W'(capacity);
      dsa_pkg::REG_HANDLE_SIZE: prdata = dsa_pkg::PDATA_W'(handle_size);
      dsa_pkg::REG_CPU_BASE:    prdata = cpu_base;
      dsa_pkg::REG_GPU_BASE:    prdata = gpu_base;
      default:                  prdata = '0;
    endcase
  end

  // Sequencing.
  dsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Busy map, counters and result.
  dsa_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .opcode       (opcode),
    .slot_number  (slot_number),
    .capacity     (capacity),
    .handle_size  (handle_size),
    .cpu_base     (cpu_base),
    .gpu_base     (gpu_base),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .status       (status),
    .granted_slot (granted_slot),
    .cpu_address  (cpu_address),
    .gpu_address  (gpu_address),
    .used_count   (used_count),
    .free_count   (free_count)
  );

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the descriptor slot allocator: directed and random
// requests, an in-order prediction of every result, and randomized flow control.
// Depends on dsa_pkg and descriptor_slot_allocator.
module tb;
  import dsa_pkg::*;

  localparam int MAX_SLOTS   = MAX_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_PCT    = 18;

  // One result transaction as the block should return it.
  typedef struct packed {
    status_t                st;
    logic [SLOT_NUM_W-1:0] slot;
    logic [ADDR_W-1:0]     cpu;
    logic [ADDR_W-1:0]     gpu;
    logic [CAP_W-1:0]      used;
    logic [CAP_W-1:0]      avail;
  } slot_outcome_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic req_valid;
  logic req_ready;
  logic [OPCODE_W-1:0] opcode;
  logic [SLOT_NUM_W-1:0] slot_number;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [SLOT_NUM_W-1:0] granted_slot;
  logic [ADDR_W-1:0] cpu_address;
  logic [ADDR_W-1:0] gpu_address;
  logic [CAP_W-1:0] used_count;
  logic [CAP_W-1:0] free_count;

  // Shadow copy of the allocator state and its registers.
  bit [CAP_W-1:0]  cfg_capacity;
  bit [HS_W-1:0]   cfg_stride;
  bit [ADDR_W-1:0] cfg_cpu_base;
  bit [ADDR_W-1:0] cfg_gpu_base;
  bit              busy_bits [MAX_SLOTS];
  int              busy_cnt;
  int              scan_ptr;

  slot_outcome_t slot_outcomes [$];
  slot_outcome_t want;
  int            error_count;
  int            cycle_count;
  bit            steady;
  int            stall_orders;
  int            stall_served;
  int            stall_left;

  descriptor_slot_allocator #(.MAX_SLOTS(MAX_SLOTS)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .req_valid(req_valid), .req_ready(req_ready), .opcode(opcode),
    .slot_number(slot_number),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .status(status),
    .granted_slot(granted_slot), .cpu_address(cpu_address), .gpu_address(gpu_address),
    .used_count(used_count), .free_count(free_count)
  );

  // Clock with a period of 10 time units.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A capacity above the map size behaves as the map size.
  function automatic int active_capacity();
    return (cfg_capacity > MAX_SLOTS) ? MAX_SLOTS : int'(cfg_capacity);
  endfunction

  // Apply one request to the shadow state and return the result it must produce.
  function automatic slot_outcome_t apply_slot_request(op_t op, logic [SLOT_NUM_W-1:0] idx);
    slot_outcome_t o;
    int cap;
    int i;
    int n;
    bit hit;
    logic [ADDR_W-1:0] off;
    cap = active_capacity();
    o = '0;
    o.st = STAT_OK;
    hit = 1'b0;
    if (cap == 0) begin
      o.st = STAT_NOINIT;
    end else begin
      case (op)
        OP_ALLOC: begin
          o.st = STAT_FULL;
          if (busy_cnt < cap) begin
            // Next-fit scan; a pointer left beyond the capacity restarts at slot zero.
            i = (scan_ptr < cap) ? scan_ptr : 0;
            n = 0;
            while (n < cap && !hit) begin
              if (!busy_bits[i]) begin
                busy_bits[i] = 1'b1;
                busy_cnt++;
                scan_ptr = (i + 1 < cap) ? i + 1 : 0;
                o.slot = SLOT_NUM_W'(i);
                o.st = STAT_OK;
                hit = 1'b1;
              end else begin
                i = (i + 1 < cap) ? i + 1 : 0;
              end
              n++;
            end
          end
        end
        OP_FREE: begin
          if (int'(idx) >= cap) begin
            o.st = STAT_BADIDX;
          end else if (!busy_bits[idx]) begin
            o.st = STAT_ALREADY;
          end else begin
            busy_bits[idx] = 1'b0;
            if (busy_cnt > 0) busy_cnt--;
            if (int'(idx) < scan_ptr) scan_ptr = int'(idx);
            o.slot = idx;
            hit = 1'b1;
          end
        end
        OP_RESET: begin
          for (int k = 0; k < MAX_SLOTS; k++) busy_bits[k] = 1'b0;
          busy_cnt = 0;
          scan_ptr = 0;
        end
        default: begin
          if (int'(idx) >= cap) begin
            o.st = STAT_BADIDX;
          end else begin
            o.slot = idx;
            hit = 1'b1;
          end
        end
      endcase
    end
    // Addresses wrap at 64 bits; counts reflect the state after the request.
    off = ADDR_W'(o.slot) * ADDR_W'(cfg_stride);
    o.cpu = hit ? cfg_cpu_base + off : '0;
    o.gpu = hit ? cfg_gpu_base + off : '0;
    o.used = CAP_W'(busy_cnt);
    o.avail = (cap > busy_cnt) ? CAP_W'(cap - busy_cnt) : '0;
    return o;
  endfunction

  // Pick a random busy slot below the capacity, or -1 when there is none.
  function automatic int find_busy_slot(int cap);
    int start;
    int j;
    start = $urandom_range(cap - 1);
    for (int k = 0; k < cap; k++) begin
      j = (start + k) % cap;
      if (busy_bits[j]) return j;
    end
    return -1;
  endfunction

  // Register write: setup cycle, then access cycle; the shadow copy follows.
  task automatic write_register(reg_idx_t r, logic [PDATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (r)
      REG_CAPACITY:    cfg_capacity = value[CAP_W-1:0];
      REG_HANDLE_SIZE: cfg_stride = value[HS_W-1:0];
      REG_CPU_BASE:    cfg_cpu_base = value;
      REG_GPU_BASE:    cfg_gpu_base = value;
      default: ;
    endcase
  endtask

  // Offer one request transaction, with random idle cycles ahead of it outside steady mode.
  task automatic issue_request(op_t op, logic [SLOT_NUM_W-1:0] idx);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_valid   <= 1'b1;
    opcode      <= op;
    slot_number <= idx;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    slot_outcomes.push_back(apply_slot_request(op, idx));
  endtask

  // Stop offering requests and wait until every outstanding result has arrived.
  task automatic drain_results();
    req_valid <= 1'b0;
    while (slot_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mixed traffic: mostly allocate and free of busy slots, some lookups,
  // occasional reset-all and fully random requests.
  task automatic run_traffic(int n_items);
    int cap;
    int pick;
    int roll;
    for (int k = 0; k < n_items; k++) begin
      cap = active_capacity();
      roll = $urandom_range(99);
      if (cap == 0 || roll >= 92) begin
        issue_request(op_t'($urandom_range(3)), SLOT_NUM_W'($urandom));
      end else if (roll < 46) begin
        issue_request(OP_ALLOC, SLOT_NUM_W'($urandom));
      end else if (roll < 80) begin
        pick = find_busy_slot(cap);
        if (pick < 0) pick = $urandom_range(cap - 1);
        issue_request(OP_FREE, SLOT_NUM_W'(pick));
      end else if (roll < 90) begin
        issue_request(OP_LOOKUP, SLOT_NUM_W'($urandom_range(cap - 1)));
      end else begin
        issue_request(OP_RESET, SLOT_NUM_W'($urandom));
      end
    end
  endtask

  // With capacity zero every request reports the heap as not initialized.
  task automatic test_uninitialized();
    write_register(REG_HANDLE_SIZE, 64'd4096);
    write_register(REG_CPU_BASE, 64'hFFFF_FFFF_FFFF_F000);
    write_register(REG_GPU_BASE, 64'h8000_0000_0000_0000);
    issue_request(OP_ALLOC, 10'd0);
    issue_request(OP_FREE, 10'd1023);
    issue_request(OP_RESET, 10'd0);
    issue_request(OP_LOOKUP, 10'd0);
    drain_results();
  endtask

  // Small heap: fill to full, lookup of the last slot, bad index, double free, reset all.
  task automatic test_basic_requests();
    write_register(REG_CAPACITY, 64'd3);
    repeat (4) issue_request(OP_ALLOC, 10'd0);
    issue_request(OP_LOOKUP, 10'd2);
    issue_request(OP_LOOKUP, 10'd3);
    issue_request(OP_FREE, 10'd1023);
    issue_request(OP_FREE, 10'd1);
    issue_request(OP_FREE, 10'd1);
    issue_request(OP_ALLOC, 10'h3FF);
    issue_request(OP_RESET, 10'd0);
    issue_request(OP_ALLOC, 10'd0);
    drain_results();
  endtask

  // Oversized capacity, zero stride, and a capacity shrunk below busy slots
  // that still count against it.
  task automatic test_capacity_limits();
    write_register(REG_CAPACITY, 64'd2047);
    issue_request(OP_LOOKUP, 10'd1023);
    issue_request(OP_ALLOC, 10'd0);
    drain_results();
    write_register(REG_HANDLE_SIZE, 64'd0);
    issue_request(OP_LOOKUP, 10'd512);
    drain_results();
    write_register(REG_CAPACITY, 64'd1);
    issue_request(OP_ALLOC, 10'd0);
    issue_request(OP_FREE, 10'd0);
    issue_request(OP_ALLOC, 10'd0);
    issue_request(OP_LOOKUP, 10'd1);
    issue_request(OP_RESET, 10'd0);
    issue_request(OP_ALLOC, 10'd0);
    drain_results();
  endtask

  // Random traffic over several register settings, one stretch without idling.
  task automatic test_random_phases();
    write_register(REG_CAPACITY, 64'd16);
    write_register(REG_HANDLE_SIZE, 64'($urandom_range(4096)));
    write_register(REG_CPU_BASE, {$urandom, $urandom});
    write_register(REG_GPU_BASE, {$urandom, $urandom});
    run_traffic(400);
    drain_results();

    write_register(REG_CAPACITY, 64'd1024);
    write_register(REG_HANDLE_SIZE, 64'd4096);
    write_register(REG_CPU_BASE, '1);
    write_register(REG_GPU_BASE, 64'd0);
    run_traffic(400);
    drain_results();

    // Full rate on both sides.
    steady = 1'b1;
    write_register(REG_CAPACITY, 64'd5);
    write_register(REG_HANDLE_SIZE, 64'd8);
    run_traffic(300);
    drain_results();
    steady = 1'b0;

    write_register(REG_CAPACITY, 64'd2047);
    write_register(REG_HANDLE_SIZE, 64'd8191);
    write_register(REG_GPU_BASE, {$urandom, $urandom});
    run_traffic(250);
    drain_results();

    write_register(REG_CAPACITY, 64'($urandom_range(64, 2)));
    write_register(REG_HANDLE_SIZE, 64'($urandom_range(4096)));
    write_register(REG_CPU_BASE, {$urandom, $urandom});
    run_traffic(300);
    drain_results();

    write_register(REG_CAPACITY, 64'd0);
    run_traffic(20);
    drain_results();
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so the
  // block fills and stalls its input; then the sender waits for every result.
  task automatic test_backpressure();
    write_register(REG_CAPACITY, 64'd40);
    stall_orders++;
    run_traffic(40);
    drain_results();
  endtask

  // Receiver: random stalls, long hold-offs on request, none in steady mode.
  always @(posedge clk) begin
    if (stall_orders != stall_served) begin
      stall_served <= stall_orders;
      stall_left   <= HOLD_CYCLES;
      rsp_ready    <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_ready  <= 1'b0;
    end else if (steady) begin
      rsp_ready <= 1'b1;
    end else begin
      rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (slot_outcomes.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("unexpected result: status %0d slot %0d", status, granted_slot);
        end
      end else begin
        want = slot_outcomes.pop_front();
        if (want.st !== status || want.slot !== granted_slot ||
            want.cpu !== cpu_address || want.gpu !== gpu_address ||
            want.used !== used_count || want.avail !== free_count) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch: expected st %0d slot %0d cpu %h gpu %h used %0d free %0d",
                     want.st, want.slot, want.cpu, want.gpu, want.used, want.avail);
            $display("          actual   st %0d slot %0d cpu %h gpu %h used %0d free %0d",
                     status, granted_slot, cpu_address, gpu_address, used_count, free_count);
          end
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    rst         <= 1'b1;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    req_valid   <= 1'b0;
    opcode      <= OP_ALLOC;
    slot_number <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_uninitialized();
    test_basic_requests();
    test_capacity_limits();
    test_random_phases();
    test_backpressure();

    drain_results();
    repeat (80) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: descriptor_slot_allocator.f
design/dsa_pkg.sv
design/dsa_ctrl.sv
design/dsa_datapath.sv
design/descriptor_slot_allocator.sv
tb/tb.sv
